/* design/pid_controller_clamped_macros.svh */
// Assertion macros for the PID controller
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PIDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define PIDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pidc_pkg.sv */
package pidc_pkg;

   // Field widths
   localparam int DATA_W    = 32;
   localparam int BOUND_W   = 31;
   localparam int FRAC_W    = 16;
   localparam int OPND_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int TERM_W    = PROD_W - FRAC_W;
   localparam int ISUM_W    = TERM_W + 1;
   localparam int ACC_W     = TERM_W + 2;
   localparam int DIVD_W    = OPND_W + FRAC_W;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_BOUND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_BOUND    = 3'd5;

   // Operation codes
   localparam logic FUNC_COMPUTE = 1'b0;
   localparam logic FUNC_CLEAR   = 1'b1;

   // Microprogram step addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ERR   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_P = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ACC_P = 4'd3;
   localparam logic [STEP_W-1:0] STEP_INT   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_I = 4'd5;
   localparam logic [STEP_W-1:0] STEP_ACC_I = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DIV   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_RATE  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_MUL_D = 4'd9;
   localparam logic [STEP_W-1:0] STEP_ACC_D = 4'd10;
   localparam logic [STEP_W-1:0] STEP_OUT   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_CLR   = 4'd12;

   typedef enum logic [1:0] {
      MUL_P   = 2'd0,
      MUL_INC = 2'd1,
      MUL_I   = 2'd2,
      MUL_D   = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [2:0] {
      JC_NEVER    = 3'd0,
      JC_ALWAYS   = 3'd1,
      JC_NO_REQ   = 3'd2,
      JC_CLEAR    = 3'd3,
      JC_ZERO_PER = 3'd4,
      JC_DIV_BUSY = 3'd5
   } jump_cond_type;

   typedef struct packed {
      logic              take_req;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              ld_err;
      logic              ld_integ;
      logic              div_init;
      logic              div_step;
      logic              ld_rate;
      logic              ld_prev;
      logic              need_out;
      logic              ld_out;
      logic              clr_state;
      jump_cond_type     jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     hit;
   } clamp_type;

   // Control store: one word per step
   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w           = '0;
      w.mul_sel   = MUL_P;
      w.acc_op    = ACC_HOLD;
      w.jump      = JC_NEVER;
      w.target    = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.take_req = 1'b1;
            w.jump     = JC_NO_REQ;
            w.target   = STEP_IDLE;
         end
         STEP_ERR: begin
            w.ld_err = 1'b1;
            w.jump   = JC_CLEAR;
            w.target = STEP_CLR;
         end
         STEP_MUL_P: begin
            w.mul_sel = MUL_P;
         end
         STEP_ACC_P: begin
            w.acc_op  = ACC_LOAD;
            w.mul_sel = MUL_INC;
         end
         STEP_INT: begin
            w.ld_integ = 1'b1;
            w.div_init = 1'b1;
         end
         STEP_MUL_I: begin
            w.mul_sel = MUL_I;
         end
         STEP_ACC_I: begin
            w.acc_op = ACC_ADD;
            w.jump   = JC_ZERO_PER;
            w.target = STEP_RATE;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.jump     = JC_DIV_BUSY;
            w.target   = STEP_DIV;
         end
         STEP_RATE: begin
            w.ld_rate = 1'b1;
         end
         STEP_MUL_D: begin
            w.mul_sel = MUL_D;
            w.ld_prev = 1'b1;
         end
         STEP_ACC_D: begin
            w.acc_op = ACC_ADD;
         end
         STEP_OUT: begin
            w.need_out = 1'b1;
            w.ld_out   = 1'b1;
            w.jump     = JC_ALWAYS;
            w.target   = STEP_IDLE;
         end
         STEP_CLR: begin
            w.need_out  = 1'b1;
            w.ld_out    = 1'b1;
            w.clr_state = 1'b1;
            w.jump      = JC_ALWAYS;
            w.target    = STEP_IDLE;
         end
         default: begin
            w.jump   = JC_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* design/pidc_req_if.sv */
interface pidc_req_if import pidc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [DATA_W-1:0] measurement;
   logic        [DATA_W-1:0] period;

   modport source (output valid, output func, output measurement, output period,
                   input ready);
   modport sink (input valid, input func, input measurement, input period,
                 output ready);
endinterface

/* design/pidc_rsp_if.sv */
interface pidc_rsp_if import pidc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] drive;
   logic                     integral_clamped;
   logic                     drive_clamped;
   logic                     zero_period;

   modport source (output valid, output drive, output integral_clamped,
                   output drive_clamped, output zero_period, input ready);
   modport sink (input valid, input drive, input integral_clamped,
                 input drive_clamped, input zero_period, output ready);
endinterface

/* design/pid_controller_clamped.sv */
// Compute beat: a new request is taken only once the sequencer is back at its idle step, so an item
// runs to its result first; the 49-step restoring divider for the derivative rate dominates the program.
// Zero period skips the divider. Clear beat: the error step branches straight to the clear step.
// A full result register that is not taken holds the sequencer at its output or clear step.
// Synchronous active-high reset zeroes gains, setpoint, bounds, integral and last error;
// there is no clearing pass.
`include "pid_controller_clamped_macros.svh"

module pid_controller_clamped import pidc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   pidc_req_if.sink             req_chan,
   pidc_rsp_if.source           rsp_chan
);

   // Sequencer
   logic [STEP_W-1:0]  step_ff, step_in;
   ctrl_word_type      ctrl;
   logic               stall;
   logic               jump_taken;
   logic               req_beat;

   // Configuration
   logic signed [DATA_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff, setpoint_ff;
   logic [BOUND_W-1:0]       integral_bound_ff, drive_bound_ff;

   // Latched request
   logic                     func_ff;
   logic signed [DATA_W-1:0] meas_ff;
   logic [DATA_W-1:0]        period_ff;

   // Datapath
   logic signed [DATA_W-1:0] err_ff, err_in;
   logic signed [DATA_W-1:0] integ_ff;
   logic signed [DATA_W-1:0] prev_ff;
   logic signed [DATA_W-1:0] rate_ff, rate_in;
   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [OPND_W-1:0] err_diff;
   logic signed [ISUM_W-1:0] isum;
   clamp_type                integ_clamp, drive_clamp;
   logic                     zero_per;
   logic                     integ_hit_ff;

   // Divider
   logic [DIVD_W-1:0]    quo_ff;
   logic [DATA_W-1:0]    rem_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic                 div_neg_ff;
   logic signed [OPND_W-1:0] rate_diff;
   logic [OPND_W-1:0]    rate_mag;
   logic [OPND_W-1:0]    rem_shift;
   logic                 q_bit;

   // Result register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] drive_ff;
   logic                     integral_clamped_ff, drive_clamped_ff, zero_period_ff;

   function automatic clamp_type clamp_mag(input logic signed [ACC_W-1:0] v,
                                           input logic [BOUND_W-1:0] bound);
      clamp_type               r;
      logic signed [ACC_W-1:0] pos;
      logic signed [ACC_W-1:0] neg;
      pos = $signed({{(ACC_W - BOUND_W){1'b0}}, bound});
      neg = -pos;
      if (v > pos) begin
         r.value = $signed({1'b0, bound});
         r.hit   = 1'b1;
      end else if (v < neg) begin
         r.value = -$signed({1'b0, bound});
         r.hit   = 1'b1;
      end else begin
         r.value = v[DATA_W-1:0];
         r.hit   = 1'b0;
      end
      return r;
   endfunction

   // Decode the current control word
   assign ctrl     = rom_word(step_ff);
   assign req_beat = req_chan.valid && ctrl.take_req;
   assign stall    = ctrl.need_out && rsp_valid_ff && !rsp_chan.ready;
   assign zero_per = (period_ff == '0);

   assign req_chan.ready = ctrl.take_req;

   // Evaluate the jump condition
   always_comb begin
      unique case (ctrl.jump)
         JC_NEVER:    jump_taken = 1'b0;
         JC_ALWAYS:   jump_taken = 1'b1;
         JC_NO_REQ:   jump_taken = !req_chan.valid;
         JC_CLEAR:    jump_taken = (func_ff == FUNC_CLEAR);
         JC_ZERO_PER: jump_taken = zero_per;
         JC_DIV_BUSY: jump_taken = (count_ff != '0);
         default:     jump_taken = 1'b0;
      endcase
   end

   // Advance the step counter
   always_comb begin
      priority if (stall) begin
         step_in = step_ff;
      end else if (jump_taken) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // Saturate the error
   always_comb begin
      err_diff = {setpoint_ff[DATA_W-1], setpoint_ff} - {meas_ff[DATA_W-1], meas_ff};
      if (err_diff[OPND_W-1] != err_diff[DATA_W-1]) begin
         err_in = err_diff[OPND_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                     : {1'b0, {(DATA_W - 1){1'b1}}};
      end else begin
         err_in = err_diff[DATA_W-1:0];
      end
   end

   // Select multiplier operands
   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_P: begin
            mul_a = {gain_p_ff[DATA_W-1], gain_p_ff};
            mul_b = {err_ff[DATA_W-1], err_ff};
         end
         MUL_INC: begin
            mul_a = {err_ff[DATA_W-1], err_ff};
            mul_b = $signed({1'b0, period_ff});
         end
         MUL_I: begin
            mul_a = {gain_i_ff[DATA_W-1], gain_i_ff};
            mul_b = {integ_ff[DATA_W-1], integ_ff};
         end
         MUL_D: begin
            mul_a = {gain_d_ff[DATA_W-1], gain_d_ff};
            mul_b = {rate_ff[DATA_W-1], rate_ff};
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign term    = prod_ff[PROD_W-1:FRAC_W];

   // Integral update and output clamp
   assign isum        = ISUM_W'(integ_ff) + ISUM_W'(term);
   assign integ_clamp = clamp_mag(ACC_W'(isum), integral_bound_ff);
   assign drive_clamp = clamp_mag(acc_ff, drive_bound_ff);

   // Divider setup and one restoring step
   assign rate_diff = {err_ff[DATA_W-1], err_ff} - {prev_ff[DATA_W-1], prev_ff};
   assign rate_mag  = rate_diff[OPND_W-1] ? OPND_W'(-rate_diff) : OPND_W'(rate_diff);
   assign rem_shift = {rem_ff, quo_ff[DIVD_W-1]};
   assign q_bit     = (rem_shift >= {1'b0, period_ff});

   // Sign and saturate the quotient; a zero period gives a zero rate
   always_comb begin
      priority if (zero_per) begin
         rate_in = '0;
      end else if (!div_neg_ff) begin
         rate_in = (quo_ff > DIVD_W'({1'b0, {(DATA_W - 1){1'b1}}}))
                   ? {1'b0, {(DATA_W - 1){1'b1}}} : quo_ff[DATA_W-1:0];
      end else begin
         rate_in = (quo_ff > DIVD_W'({1'b1, {(DATA_W - 1){1'b0}}}))
                   ? {1'b1, {(DATA_W - 1){1'b0}}} : -quo_ff[DATA_W-1:0];
      end
   end

   // Control state, configuration and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff           <= STEP_IDLE;
         rsp_valid_ff      <= 1'b0;
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         setpoint_ff       <= '0;
         integral_bound_ff <= '0;
         drive_bound_ff    <= '0;
         integ_ff          <= '0;
         prev_ff           <= '0;
      end else begin
         step_ff <= step_in;

         if (ctrl.ld_out && !stall) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GAIN_P:         gain_p_ff         <= csr_wdata;
               CSR_GAIN_I:         gain_i_ff         <= csr_wdata;
               CSR_GAIN_D:         gain_d_ff         <= csr_wdata;
               CSR_SETPOINT:       setpoint_ff       <= csr_wdata;
               CSR_INTEGRAL_BOUND: integral_bound_ff <= csr_wdata[BOUND_W-1:0];
               CSR_DRIVE_BOUND:    drive_bound_ff    <= csr_wdata[BOUND_W-1:0];
               default: ;
            endcase
         end

         if (ctrl.clr_state && !stall) begin
            integ_ff <= '0;
            prev_ff  <= '0;
         end else begin
            if (ctrl.ld_integ) begin
               integ_ff <= integ_clamp.value;
            end
            if (ctrl.ld_prev) begin
               prev_ff <= err_ff;
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff   <= req_chan.func;
         meas_ff   <= req_chan.measurement;
         period_ff <= req_chan.period;
      end

      prod_ff <= prod_in;

      if (ctrl.ld_err) begin
         err_ff <= err_in;
      end

      unique case (ctrl.acc_op)
         ACC_HOLD: acc_ff <= acc_ff;
         ACC_LOAD: acc_ff <= ACC_W'(term);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(term);
         default:  acc_ff <= acc_ff;
      endcase

      // Hold the integral hit flag until the result is loaded
      if (ctrl.ld_integ) begin
         integ_hit_ff <= integ_clamp.hit;
      end

      if (ctrl.div_init) begin
         quo_ff     <= {rate_mag, {FRAC_W{1'b0}}};
         rem_ff     <= '0;
         count_ff   <= DIV_LAST;
         div_neg_ff <= rate_diff[OPND_W-1];
      end else if (ctrl.div_step) begin
         quo_ff   <= {quo_ff[DIVD_W-2:0], q_bit};
         rem_ff   <= q_bit ? DATA_W'(rem_shift - {1'b0, period_ff}) : rem_shift[DATA_W-1:0];
         count_ff <= count_ff - DIV_CNT_W'(1);
      end

      if (ctrl.ld_rate) begin
         rate_ff <= rate_in;
      end

      // Load the result beat
      if (ctrl.ld_out && !stall) begin
         if (ctrl.clr_state) begin
            drive_ff            <= '0;
            drive_clamped_ff    <= 1'b0;
            zero_period_ff      <= 1'b0;
            integral_clamped_ff <= 1'b0;
         end else begin
            drive_ff            <= drive_clamp.value;
            drive_clamped_ff    <= drive_clamp.hit;
            zero_period_ff      <= zero_per;
            integral_clamped_ff <= integ_hit_ff;
         end
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.drive            = drive_ff;
   assign rsp_chan.integral_clamped = integral_clamped_ff;
   assign rsp_chan.drive_clamped    = drive_clamped_ff;
   assign rsp_chan.zero_period      = zero_period_ff;

   // Assertions
   `PIDC_ASSERT_NEXT(a_beat_starts_err, clock, reset, req_beat, step_ff == STEP_ERR, "beat did not start the program")
   `PIDC_ASSERT_NOW(a_busy_not_ready, clock, reset, step_ff != STEP_IDLE, !req_chan.ready, "ready while an item is in flight")
   `PIDC_ASSERT_NOW(a_div_count_range, clock, reset, step_ff == STEP_DIV, count_ff <= DIV_LAST, "divider count out of range")

endmodule
